// ===== rtl/addressable_led_serializer_unit_macros.svh =====
// Assertion macros shared by the LED serializer RTL.
// Every macro expects signals named clk and rst_n in the including scope.
`ifndef ADDRESSABLE_LED_SERIALIZER_UNIT_MACROS_SVH
`define ADDRESSABLE_LED_SERIALIZER_UNIT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ALS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define ALS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/als_pkg.sv =====
// Shared types, constants and helper functions for the LED serializer.
// No dependencies; the controller, datapath and top RTL files refer to this package by scoped names.
package als_pkg;

  // Pixel store geometry
  localparam int MAX_PIXELS = 256;
  localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int PIX_CNT_W  = 9;
  localparam int LC_W       = (CNT_W > PIX_CNT_W) ? CNT_W : PIX_CNT_W;

  // Item and register widths
  localparam int KIND_W     = 2;
  localparam int IDX_W      = 16;
  localparam int CHAN_W     = 8;
  localparam int PIXEL_W    = 3 * CHAN_W;
  localparam int BIT_POS_W  = 5;
  localparam int TICK_W     = 12;
  localparam int LATCH_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [BIT_POS_W-1:0] LAST_BIT = BIT_POS_W'(PIXEL_W - 1);

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FILL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REFRESH = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH       = 3'd5;

  // Register reset values
  localparam logic [PIX_CNT_W-1:0] PIXEL_COUNT_RST = 9'd256;
  localparam logic [TICK_W-1:0]    ZERO_HIGH_RST   = 12'd39;
  localparam logic [TICK_W-1:0]    ZERO_LOW_RST    = 12'd85;
  localparam logic [TICK_W-1:0]    ONE_HIGH_RST    = 12'd80;
  localparam logic [TICK_W-1:0]    ONE_LOW_RST     = 12'd46;
  localparam logic [LATCH_W-1:0]   LATCH_RST       = 20'd30000;

  // Waveform phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;
  localparam logic [1:0] PH_LATCH = 2'd3;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FILL = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // input item taken this cycle
    logic fill_step;  // write one pixel of the fill range
    logic load_px;    // fetched pixel word is valid, start its first bit
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill_go;    // item is a fill that will be carried out
    logic need_load;  // item needs a pixel fetched from the store
    logic fill_last;  // current fill address is the end of the range
  } dp_sts_t;

  // Pixel count as used: zero acts as one, clamp at the store size
  function automatic logic [LC_W-1:0] live_count(input logic [PIX_CNT_W-1:0] pc);
    logic [LC_W-1:0] n;
    n = LC_W'(pc);
    if (pc == '0) begin
      n = LC_W'(1);
    end else if (n > LC_W'(MAX_PIXELS)) begin
      n = LC_W'(MAX_PIXELS);
    end
    return n;
  endfunction

  // Phase length: zero acts as one
  function automatic logic [LATCH_W-1:0] at_least_one(input logic [LATCH_W-1:0] v);
    return (v == '0) ? LATCH_W'(1) : v;
  endfunction

endpackage

// ===== rtl/als_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module als_ram #(
  parameter int  WIDTH = 24,
  parameter int  DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/als_ctrl.sv =====
// Controller: handshake on both channels and the sequencing of fills and pixel fetches.
// Depends on als_pkg.
module als_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  als_pkg::dp_sts_t  sts,
  output als_pkg::ctrl_cmd_t cmd
);

  als_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  // Take an item only when idle and the result slot is free or draining
  assign in_stall = (state_r != als_pkg::S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // Result slot: filled on every accepted item
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      als_pkg::S_IDLE: begin
        if (accept && sts.fill_go) begin
          state_nxt = als_pkg::S_FILL;
        end else if (accept && sts.need_load) begin
          state_nxt = als_pkg::S_LOAD;
        end
      end
      als_pkg::S_FILL: begin
        if (sts.fill_last) begin
          state_nxt = als_pkg::S_IDLE;
        end
      end
      als_pkg::S_LOAD: begin
        state_nxt = als_pkg::S_IDLE;
      end
      default: begin
        state_nxt = als_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= als_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Commands
  assign cmd.accept    = accept;
  assign cmd.fill_step = (state_r == als_pkg::S_FILL);
  assign cmd.load_px   = (state_r == als_pkg::S_LOAD);
  assign out_valid     = out_valid_r;

endmodule

// ===== rtl/als_datapath.sv =====
// Datapath: configuration registers, pixel store, waveform counters and result register.
// Depends on als_pkg, als_ram and the assertion macro header.
`include "addressable_led_serializer_unit_macros.svh"

module als_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  als_pkg::ctrl_cmd_t               cmd,
  output als_pkg::dp_sts_t                 sts,
  input  logic                             cfg_we,
  input  logic [als_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [als_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [als_pkg::KIND_W-1:0]       in_kind,
  input  logic [als_pkg::IDX_W-1:0]        in_start_index,
  input  logic [als_pkg::IDX_W-1:0]        in_end_index,
  input  logic [als_pkg::CHAN_W-1:0]       in_green,
  input  logic [als_pkg::CHAN_W-1:0]       in_red,
  input  logic [als_pkg::CHAN_W-1:0]       in_blue,
  output logic                             out_line_level,
  output logic                             out_busy_res,
  output logic                             out_accepted,
  output logic                             out_frame_done
);

  localparam int AW  = als_pkg::ADDR_W;
  localparam int PW  = als_pkg::PIXEL_W;
  localparam int LW  = als_pkg::LATCH_W;
  localparam int BW  = als_pkg::BIT_POS_W;
  localparam int LCW = als_pkg::LC_W;
  localparam int IW  = als_pkg::IDX_W;

  // Configuration registers
  logic [als_pkg::PIX_CNT_W-1:0] pixel_count_r;
  logic [als_pkg::TICK_W-1:0]    zero_high_r, zero_low_r, one_high_r, one_low_r;
  logic [LW-1:0]                 latch_r;

  // Waveform state
  logic          line_r, line_nxt;
  logic          sending_r, sending_nxt;
  logic [AW-1:0] pixel_pos_r, pixel_pos_nxt;
  logic [BW-1:0] bit_pos_r, bit_pos_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [LW-1:0] phase_count_r, phase_count_nxt;
  logic [PW-1:0] cur_px_r, cur_px_nxt;

  // Fill state
  logic [AW-1:0] fill_addr_r, fill_addr_nxt;
  logic [AW-1:0] fill_end_r, fill_end_nxt;
  logic [PW-1:0] colour_r, colour_nxt;

  // Store read side
  logic [als_pkg::MAX_PIXELS-1:0] valid_r;
  logic                           rd_ok_r;
  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;
  logic [PW-1:0]                  ram_rdata;
  logic [PW-1:0]                  rd_word;

  // Decoded item
  logic [LCW-1:0] live_n;
  logic [IW-1:0]  n_idx, lo, hi, hi_cl;
  logic           fill_ok;
  logic           is_tick, is_fill, is_refresh;

  // State after a tick
  logic          t_line, t_sending, t_shift, t_done, t_fetch;
  logic [AW-1:0] t_pix;
  logic [BW-1:0] t_bit;
  logic [1:0]    t_phase;
  logic [LW-1:0] t_count;
  logic [LCW-1:0] pix_plus1;

  // Result
  logic res_level, res_busy, res_acc, res_done;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r <= als_pkg::PIXEL_COUNT_RST;
      zero_high_r   <= als_pkg::ZERO_HIGH_RST;
      zero_low_r    <= als_pkg::ZERO_LOW_RST;
      one_high_r    <= als_pkg::ONE_HIGH_RST;
      one_low_r     <= als_pkg::ONE_LOW_RST;
      latch_r       <= als_pkg::LATCH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        als_pkg::REG_PIXEL_COUNT: pixel_count_r <= cfg_wdata[als_pkg::PIX_CNT_W-1:0];
        als_pkg::REG_ZERO_HIGH:   zero_high_r   <= cfg_wdata[als_pkg::TICK_W-1:0];
        als_pkg::REG_ZERO_LOW:    zero_low_r    <= cfg_wdata[als_pkg::TICK_W-1:0];
        als_pkg::REG_ONE_HIGH:    one_high_r    <= cfg_wdata[als_pkg::TICK_W-1:0];
        als_pkg::REG_ONE_LOW:     one_low_r     <= cfg_wdata[als_pkg::TICK_W-1:0];
        als_pkg::REG_LATCH:       latch_r       <= cfg_wdata[LW-1:0];
        default: ;
      endcase
    end
  end

  assign is_tick    = (in_kind == als_pkg::KIND_TICK);
  assign is_fill    = (in_kind == als_pkg::KIND_FILL);
  assign is_refresh = (in_kind == als_pkg::KIND_REFRESH);

  // Fill range: order the ends, drop if start is past the count, clamp the end
  assign live_n  = als_pkg::live_count(pixel_count_r);
  assign n_idx   = IW'(live_n);
  assign lo      = (in_start_index > in_end_index) ? in_end_index : in_start_index;
  assign hi      = (in_start_index > in_end_index) ? in_start_index : in_end_index;
  assign fill_ok = (lo < n_idx);
  assign hi_cl   = (hi >= n_idx) ? (n_idx - IW'(1)) : hi;

  // One tick of the waveform; the current bit is always the top of cur_px_r
  assign pix_plus1 = LCW'(pixel_pos_r) + LCW'(1);

  always_comb begin
    t_phase   = phase_r;
    t_count   = phase_count_r;
    t_line    = line_r;
    t_sending = sending_r;
    t_pix     = pixel_pos_r;
    t_bit     = bit_pos_r;
    t_shift   = 1'b0;
    t_done    = 1'b0;
    t_fetch   = 1'b0;
    if (phase_r != als_pkg::PH_IDLE) begin
      if (phase_count_r > LW'(1)) begin
        t_count = phase_count_r - LW'(1);
      end else begin
        case (phase_r)
          als_pkg::PH_HIGH: begin
            t_phase = als_pkg::PH_LOW;
            t_line  = 1'b0;
            t_count = als_pkg::at_least_one(LW'(cur_px_r[PW-1] ? one_low_r : zero_low_r));
          end
          als_pkg::PH_LOW: begin
            if (bit_pos_r == als_pkg::LAST_BIT) begin
              t_bit = '0;
              if (pix_plus1 >= live_n) begin
                t_phase = als_pkg::PH_LATCH;
                t_line  = 1'b0;
                t_count = als_pkg::at_least_one(latch_r);
              end else begin
                // next pixel comes from the store; its first bit starts on the load
                t_pix   = pixel_pos_r + AW'(1);
                t_fetch = 1'b1;
              end
            end else begin
              t_bit   = bit_pos_r + BW'(1);
              t_shift = 1'b1;
              t_phase = als_pkg::PH_HIGH;
              t_line  = 1'b1;
              t_count = als_pkg::at_least_one(LW'(cur_px_r[PW-2] ? one_high_r : zero_high_r));
            end
          end
          als_pkg::PH_LATCH: begin
            t_phase   = als_pkg::PH_IDLE;
            t_count   = '0;
            t_sending = 1'b0;
            t_pix     = '0;
            t_bit     = '0;
            t_line    = 1'b0;
            t_done    = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Status to the controller
  assign sts.fill_go   = is_fill && !sending_r && fill_ok;
  assign sts.need_load = (is_tick && t_fetch) || (is_refresh && !sending_r);
  assign sts.fill_last = (fill_addr_r == fill_end_r);

  // Result of the item
  always_comb begin
    res_level = line_r;
    res_busy  = sending_r;
    res_acc   = 1'b0;
    res_done  = 1'b0;
    case (in_kind)
      als_pkg::KIND_TICK: begin
        res_busy = t_sending;
        res_done = t_done;
      end
      als_pkg::KIND_FILL: begin
        res_acc = !sending_r && fill_ok;
      end
      als_pkg::KIND_REFRESH: begin
        if (!sending_r) begin
          res_level = 1'b1;
          res_busy  = 1'b1;
          res_acc   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Next-state selection
  always_comb begin
    line_nxt        = line_r;
    sending_nxt     = sending_r;
    pixel_pos_nxt   = pixel_pos_r;
    bit_pos_nxt     = bit_pos_r;
    phase_nxt       = phase_r;
    phase_count_nxt = phase_count_r;
    cur_px_nxt      = cur_px_r;
    fill_addr_nxt   = fill_addr_r;
    fill_end_nxt    = fill_end_r;
    colour_nxt      = colour_r;
    if (cmd.accept) begin
      case (in_kind)
        als_pkg::KIND_TICK: begin
          line_nxt        = t_line;
          sending_nxt     = t_sending;
          pixel_pos_nxt   = t_pix;
          bit_pos_nxt     = t_bit;
          phase_nxt       = t_phase;
          phase_count_nxt = t_count;
          if (t_shift) begin
            cur_px_nxt = {cur_px_r[PW-2:0], 1'b0};
          end
        end
        als_pkg::KIND_FILL: begin
          fill_addr_nxt = AW'(lo);
          fill_end_nxt  = AW'(hi_cl);
          colour_nxt    = {in_green, in_red, in_blue};
        end
        als_pkg::KIND_REFRESH: begin
          if (!sending_r) begin
            sending_nxt   = 1'b1;
            pixel_pos_nxt = '0;
            bit_pos_nxt   = '0;
          end
        end
        default: ;
      endcase
    end
    // Start the first bit of a freshly fetched pixel
    if (cmd.load_px) begin
      phase_nxt       = als_pkg::PH_HIGH;
      line_nxt        = 1'b1;
      cur_px_nxt      = rd_word;
      phase_count_nxt = als_pkg::at_least_one(LW'(rd_word[PW-1] ? one_high_r : zero_high_r));
    end
    if (cmd.fill_step) begin
      fill_addr_nxt = fill_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r        <= 1'b1;
      sending_r     <= 1'b0;
      pixel_pos_r   <= '0;
      bit_pos_r     <= '0;
      phase_r       <= als_pkg::PH_IDLE;
      phase_count_r <= '0;
    end else begin
      line_r        <= line_nxt;
      sending_r     <= sending_nxt;
      pixel_pos_r   <= pixel_pos_nxt;
      bit_pos_r     <= bit_pos_nxt;
      phase_r       <= phase_nxt;
      phase_count_r <= phase_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_px_r    <= cur_px_nxt;
    fill_addr_r <= fill_addr_nxt;
    fill_end_r  <= fill_end_nxt;
    colour_r    <= colour_nxt;
  end

  // Result register, written once per accepted item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_line_level <= res_level;
      out_busy_res   <= res_busy;
      out_accepted   <= res_acc;
      out_frame_done <= res_done;
    end
  end

  // Pixel store; entries never filled since reset read as black
  assign rd_en   = cmd.accept && sts.need_load;
  assign rd_addr = is_refresh ? '0 : t_pix;
  assign rd_word = rd_ok_r ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.fill_step) begin
      valid_r[fill_addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ok_r <= valid_r[rd_addr];
    end
  end

  als_ram #(
    .WIDTH(PW),
    .DEPTH(als_pkg::MAX_PIXELS)
  ) u_store (
    .clk  (clk),
    .we   (cmd.fill_step),
    .waddr(fill_addr_r),
    .wdata(colour_r),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  // Checks
  `ALS_ASSERT(a_idle_when_not_sending, !sending_r |-> (phase_r == als_pkg::PH_IDLE), "phase active without a frame")
  `ALS_ASSERT(a_high_drives_line, (phase_r == als_pkg::PH_HIGH) |-> line_r, "line low during high phase")
  `ALS_ASSERT_NEVER(a_count_nonzero, (phase_r != als_pkg::PH_IDLE) && (phase_count_r == '0), "active phase with zero count")
  `ALS_ASSERT(a_load_in_frame, cmd.load_px |-> sending_r, "pixel load outside a frame")

endmodule

// ===== rtl/addressable_led_serializer_unit.sv =====
// Addressable LED serializer. Each result is registered and appears the cycle after its item.
// A tick that moves to the next pixel and a refresh that starts a frame pass through the load
// state, set by the registered read of the pixel store; a fill that is carried out stays in
// the fill state for one store write per pixel of its range. The input waits in those states
// and while a result is held by out_stall. Reset (rst_n low, synchronous) idles the line high
// and marks every pixel entry unwritten, so the store reads black.
module addressable_led_serializer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [als_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [als_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [als_pkg::KIND_W-1:0]     in_kind,
  input  logic [als_pkg::IDX_W-1:0]      in_start_index,
  input  logic [als_pkg::IDX_W-1:0]      in_end_index,
  input  logic [als_pkg::CHAN_W-1:0]     in_green,
  input  logic [als_pkg::CHAN_W-1:0]     in_red,
  input  logic [als_pkg::CHAN_W-1:0]     in_blue,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_line_level,
  output logic                           out_busy_res,
  output logic                           out_accepted,
  output logic                           out_frame_done
);

  als_pkg::ctrl_cmd_t cmd;
  als_pkg::dp_sts_t   sts;

  // Sequencing and handshake
  als_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store, counters and result register
  als_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_kind       (in_kind),
    .in_start_index(in_start_index),
    .in_end_index  (in_end_index),
    .in_green      (in_green),
    .in_red        (in_red),
    .in_blue       (in_blue),
    .out_line_level(out_line_level),
    .out_busy_res  (out_busy_res),
    .out_accepted  (out_accepted),
    .out_frame_done(out_frame_done)
  );

endmodule

// ===== test/tb_addressable_led_serializer_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for addressable_led_serializer_unit (fill, refresh and tick items).
// Depends on rtl/als_pkg.sv for widths, item kinds, register indexes and phase codes.
module tb_addressable_led_serializer_unit;
  import als_pkg::*;

  localparam int CLK_HALF_NS = 4;
  localparam int TIMEOUT_NS = 5_000_000;
  localparam int TARGET_ITEMS = 600;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef enum {PAINT_RANDOM, PAINT_BLACK, PAINT_WHITE} paint_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } led_status_t;

  // Predicts the line level and status for each item and checks them in order
  class strip_scoreboard;
    int unsigned pixel_count, zero_high, zero_low, one_high, one_low, latch_len;
    logic [PIXEL_W-1:0] pixels [MAX_PIXELS];
    bit line, sending;
    logic [1:0] phase;
    int unsigned pixel_pos, bit_pos, ticks_left;
    led_status_t expected[$];
    int errors, checked, frames;

    function new();
      pixel_count = 32'(PIXEL_COUNT_RST);
      zero_high = 32'(ZERO_HIGH_RST);
      zero_low = 32'(ZERO_LOW_RST);
      one_high = 32'(ONE_HIGH_RST);
      one_low = 32'(ONE_LOW_RST);
      latch_len = 32'(LATCH_RST);
      foreach (pixels[i]) pixels[i] = '0;
      line = 1'b1;
      sending = 1'b0;
      phase = PH_IDLE;
      pixel_pos = 0;
      bit_pos = 0;
      ticks_left = 0;
      errors = 0;
      checked = 0;
      frames = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PIXEL_COUNT: pixel_count = 32'(val[PIX_CNT_W-1:0]);
        REG_ZERO_HIGH:   zero_high = 32'(val[TICK_W-1:0]);
        REG_ZERO_LOW:    zero_low = 32'(val[TICK_W-1:0]);
        REG_ONE_HIGH:    one_high = 32'(val[TICK_W-1:0]);
        REG_ONE_LOW:     one_low = 32'(val[TICK_W-1:0]);
        REG_LATCH:       latch_len = 32'(val[LATCH_W-1:0]);
        default: ;
      endcase
    endfunction

    // Count of 0 behaves as 1, anything past the store size is clamped
    function int unsigned active_pixels();
      if (pixel_count == 0) return 1;
      if (pixel_count > MAX_PIXELS) return MAX_PIXELS;
      return pixel_count;
    endfunction

    function int unsigned ticks_or_one(int unsigned v);
      return (v == 0) ? 1 : v;
    endfunction

    function bit bit_now();
      return pixels[pixel_pos][PIXEL_W - 1 - bit_pos];
    endfunction

    function void start_high();
      phase = PH_HIGH;
      line = 1'b1;
      ticks_left = ticks_or_one(bit_now() ? one_high : zero_high);
    endfunction

    // One clock tick of the waveform; returns 1 when the latch period ends
    function bit advance_tick();
      if (phase == PH_IDLE) return 1'b0;
      if (ticks_left > 1) begin
        ticks_left--;
        return 1'b0;
      end
      case (phase)
        PH_HIGH: begin
          phase = PH_LOW;
          line = 1'b0;
          ticks_left = ticks_or_one(bit_now() ? one_low : zero_low);
        end
        PH_LOW: begin
          bit_pos++;
          if (bit_pos >= PIXEL_W) begin
            bit_pos = 0;
            pixel_pos++;
            // pixel count is sampled here, at the end of each pixel
            if (pixel_pos >= active_pixels()) begin
              phase = PH_LATCH;
              line = 1'b0;
              ticks_left = ticks_or_one(latch_len);
              return 1'b0;
            end
          end
          start_high();
        end
        default: begin
          phase = PH_IDLE;
          ticks_left = 0;
          sending = 1'b0;
          pixel_pos = 0;
          bit_pos = 0;
          line = 1'b0;
          frames++;
          return 1'b1;
        end
      endcase
      return 1'b0;
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] s_idx,
                            logic [IDX_W-1:0] e_idx, logic [PIXEL_W-1:0] color);
      led_status_t res;
      int unsigned lo, hi, n, i;
      res.line_level = line;
      res.accepted = 1'b0;
      res.frame_done = 1'b0;
      case (kind)
        KIND_TICK: res.frame_done = advance_tick();
        KIND_FILL: begin
          if (!sending) begin
            n = active_pixels();
            lo = 32'(s_idx);
            hi = 32'(e_idx);
            if (lo > hi) begin
              lo = 32'(e_idx);
              hi = 32'(s_idx);
            end
            if (lo < n) begin
              if (hi >= n) hi = n - 1;
              for (i = lo; i <= hi; i++) pixels[i] = color;
              res.accepted = 1'b1;
            end
          end
        end
        KIND_REFRESH: begin
          if (!sending) begin
            sending = 1'b1;
            pixel_pos = 0;
            bit_pos = 0;
            start_high();
            res.accepted = 1'b1;
            res.line_level = line;
          end
        end
        default: ;
      endcase
      res.busy_res = sending;
      expected.push_back(res);
    endfunction

    function void compare_field(string name, logic want, logic got);
      if (got !== want) begin
        $error("%s: expected %0b, got %0b", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(led_status_t got);
      led_status_t want;
      if (expected.size() == 0) begin
        $error("result arrived with no item outstanding");
        errors++;
        return;
      end
      want = expected.pop_front();
      checked++;
      compare_field("line_level", want.line_level, got.line_level);
      compare_field("busy_res", want.busy_res, got.busy_res);
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("frame_done", want.frame_done, got.frame_done);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [KIND_W-1:0] in_kind;
  logic [IDX_W-1:0] in_start_index;
  logic [IDX_W-1:0] in_end_index;
  logic [CHAN_W-1:0] in_green;
  logic [CHAN_W-1:0] in_red;
  logic [CHAN_W-1:0] in_blue;
  logic out_valid;
  logic out_stall;
  logic out_line_level;
  logic out_busy_res;
  logic out_accepted;
  logic out_frame_done;

  strip_scoreboard sb;
  int in_gap_pct = 10;
  int out_stall_pct = 10;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int cfg_writes = 0;

  addressable_led_serializer_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_start_index(in_start_index),
    .in_end_index(in_end_index),
    .in_green(in_green),
    .in_red(in_red),
    .in_blue(in_blue),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_line_level(out_line_level),
    .out_busy_res(out_busy_res),
    .out_accepted(out_accepted),
    .out_frame_done(out_frame_done)
  );

  // 8 ns clock
  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_result(led_status_t'({out_line_level, out_busy_res, out_accepted,
                                     out_frame_done}));
    end
  end

  // Receiver: random stalls, occasional long ones, one long hold on request
  initial begin : result_sink
    int len;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end else if ($urandom_range(0, 99) < out_stall_pct) begin
        out_stall <= 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(8, 30);
          repeat (len) @(negedge clk);
        end
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #TIMEOUT_NS;
    $display("addressable_led_serializer_unit: mismatch");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= in_gap_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_pct();
    int choices[4] = '{0, 10, 30, 60};
    return choices[$urandom_range(0, 3)];
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_color(paint_t paint);
    case (paint)
      PAINT_BLACK: return '0;
      PAINT_WHITE: return '1;
      default: return PIXEL_W'($urandom);
    endcase
  endfunction

  // Random bits above the register width; the block must ignore them
  function automatic logic [CFG_DATA_W-1:0] with_upper_noise(int unsigned v, int w, bit junk);
    logic [CFG_DATA_W-1:0] r;
    r = CFG_DATA_W'(v);
    if (junk && w < CFG_DATA_W) r = r | (CFG_DATA_W'($urandom) << w);
    return r;
  endfunction

  // Offer one item, hold it until taken, then record it
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] s_idx,
                           input logic [IDX_W-1:0] e_idx, input logic [PIXEL_W-1:0] color);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_start_index <= s_idx;
    in_end_index <= e_idx;
    {in_green, in_red, in_blue} <= color;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_item(kind, s_idx, e_idx, color);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, IDX_W'($urandom), IDX_W'($urandom), PIXEL_W'($urandom));
  endtask

  // Any kind with random indexes; only kinds that cannot advance the frame while busy
  task automatic send_noise(input paint_t paint, input bit busy);
    logic [KIND_W-1:0] kind;
    kind = busy ? KIND_W'($urandom_range(1, 3)) : KIND_W'($urandom_range(0, 3));
    send_item(kind, IDX_W'($urandom), IDX_W'($urandom), pick_color(paint));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic set_timing(input int unsigned cnt, input int unsigned zh, input int unsigned zl,
                            input int unsigned oh, input int unsigned ol,
                            input int unsigned latch, input bit junk);
    write_reg(REG_PIXEL_COUNT, with_upper_noise(cnt, PIX_CNT_W, junk));
    write_reg(REG_ZERO_HIGH, with_upper_noise(zh, TICK_W, junk));
    write_reg(REG_ZERO_LOW, with_upper_noise(zl, TICK_W, junk));
    write_reg(REG_ONE_HIGH, with_upper_noise(oh, TICK_W, junk));
    write_reg(REG_ONE_LOW, with_upper_noise(ol, TICK_W, junk));
    write_reg(REG_LATCH, with_upper_noise(latch, LATCH_W, junk));
  endtask

  // Let every outstanding result come back before touching the registers
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Some noise, a few fills, a refresh, then ticks through the frame
  task automatic run_sequence(input bit early, input paint_t paint, input bit wide);
    int unsigned lo, hi, n, limit, ticks;
    repeat ($urandom_range(0, 2)) send_noise(paint, sb.sending);
    repeat ($urandom_range(0, 3)) begin
      n = sb.active_pixels();
      lo = $urandom_range(0, n - 1);
      hi = wide ? $urandom_range(0, 65535) : $urandom_range(0, n - 1);
      if ($urandom_range(0, 1) == 1) send_item(KIND_FILL, IDX_W'(lo), IDX_W'(hi), pick_color(paint));
      else send_item(KIND_FILL, IDX_W'(hi), IDX_W'(lo), pick_color(paint));
    end
    send_item(KIND_REFRESH, IDX_W'($urandom), IDX_W'($urandom), PIXEL_W'($urandom));
    limit = $urandom_range(1, 30);
    ticks = 0;
    while (sb.sending && (!early || ticks < limit)) begin
      if ($urandom_range(0, 99) < 8) begin
        send_noise(paint, 1'b1);
      end else begin
        send_tick();
        ticks++;
      end
    end
    // idle ticks after the frame change nothing
    if (!early) repeat ($urandom_range(0, 2)) send_tick();
  endtask

  task automatic run_phase(input int p);
    int seqs;
    bit early;
    paint_t paint;
    bit wide;
    drain();
    in_gap_pct = pick_pct();
    out_stall_pct = pick_pct();
    early = 1'b0;
    paint = PAINT_RANDOM;
    wide = 1'b0;
    seqs = $urandom_range(2, 4);
    case (p)
      0: begin
        // frame from the directed part still runs; latch at its maximum for now
        set_timing(0, 0, 1, 4095, 4095, 20'hFFFFF, 1'b0);
        early = 1'b1;
        paint = PAINT_BLACK;
        seqs = 1;
      end
      1: begin
        // no idling on either side; latch of 0 acts as 1
        set_timing(1, 1, 2, 2, 1, 0, 1'b0);
        in_gap_pct = 0;
        out_stall_pct = 0;
        seqs = 2;
      end
      2: begin
        // all-ones pixels, so the maximum zero-bit lengths stay unused
        set_timing(1, 4095, 4095, 0, 2, 3, 1'b0);
        paint = PAINT_WHITE;
        seqs = 1;
        // the only pixel sent is painted white before any frame can start
        send_item(KIND_FILL, '0, '0, '1);
      end
      3: begin
        // full store; frame is cut short and finished under a smaller count
        set_timing(256, 1, 1, 1, 1, 2, 1'b0);
        early = 1'b1;
        wide = 1'b1;
        seqs = 1;
      end
      4: begin
        set_timing(2, 2, 1, 1, 2, 5, 1'b0);
        in_gap_pct = 0;
        hold_req = 1'b1;
        seqs = 1;
      end
      5: begin
        // count above the store size acts as the store size
        set_timing(511, 0, 0, 0, 0, 1, 1'b0);
        early = 1'b1;
        wide = 1'b1;
        seqs = 1;
      end
      default: begin
        set_timing(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2),
                   $urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 2),
                   $urandom_range(0, 2),
                   ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(4, 40),
                   1'b1);
      end
    endcase
    repeat (seqs) begin
      // random phases stop adding frames once the item budget is spent
      if (p <= 5 || items_sent < TARGET_ITEMS) begin
        run_sequence(early || (p > 5 && $urandom_range(0, 99) < 15), paint, wide);
      end
    end
  endtask

  initial begin : stimulus
    int p;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_kind = KIND_TICK;
    in_start_index = '0;
    in_end_index = '0;
    in_green = '0;
    in_red = '0;
    in_blue = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset state, ignored and clamped fills, reversed range, busy refresh
    send_tick();
    send_item(KIND_UNUSED, '0, '0, '0);
    send_item(KIND_FILL, 16'hFFFF, 16'hFFFF, 24'h123456);
    send_item(KIND_FILL, 16'd256, 16'd300, 24'h654321);
    send_item(KIND_FILL, 16'hFFFF, 16'd1, 24'hFFFFFF);
    send_item(KIND_FILL, 16'd0, 16'd0, 24'h000000);
    send_item(KIND_FILL, 16'd2, 16'd2, 24'hAA550F);
    send_item(KIND_FILL, 16'd255, 16'd255, 24'h00FF80);
    send_item(KIND_REFRESH, '0, '0, '0);
    send_item(KIND_FILL, 16'd0, 16'd0, 24'hFFFFFF);
    send_item(KIND_REFRESH, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    send_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    repeat (5) send_tick();

    // Random phases, each under its own register setting
    p = 0;
    while (p < 6 || items_sent < TARGET_ITEMS) begin
      run_phase(p);
      p++;
    end

    drain();
    $display("sent %0d items over %0d register settings (%0d register writes)",
             items_sent, p, cfg_writes);
    $display("checked %0d results; %0d frames ran through their latch period",
             sb.checked, sb.frames);
    if (sb.errors == 0) begin
      $display("addressable_led_serializer_unit: match");
    end else begin
      $display("addressable_led_serializer_unit: mismatch");
    end
    $finish;
  end

endmodule
